### rtl/core/i2cbm_pkg.sv
// shared types and constants for the i2c bit-level master core
// no dependencies

package i2cbm_pkg;

   typedef enum logic [2:0] {
      OP_START  = 3'd0,
      OP_STOP   = 3'd1,
      OP_WRITE  = 3'd2,
      OP_READ   = 3'd3,
      OP_ACK    = 3'd4,
      OP_NACK   = 3'd5,
      OP_GETACK = 3'd6
   } opcode_type;

   localparam logic [3:0] BITS_PER_BYTE = 4'd8;
   localparam logic [7:0] TIMEOUT_RESET = 8'd200;

   // one tick as it arrives on the request channel
   typedef struct packed {
      logic       cmd_valid;
      logic [2:0] opcode;
      logic [7:0] tx_byte;
      logic       sda_sample;
   } req_type;

   // one tick result
   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_byte;
      logic       ack_ok;
   } rsp_type;

   // classified tick held in the queue
   typedef struct packed {
      logic       start;
      opcode_type op;
      logic [7:0] tx_byte;
      logic       sda_sample;
   } tick_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

### rtl/core/i2cbm_front.sv
// front end: classifies incoming ticks and pushes them into the queue
// depends on i2cbm_pkg

module i2cbm_front
   import i2cbm_pkg::*;
(
   input  logic             req_valid,
   input  req_type          req_data,
   input  queue_status_type q_status,
   output logic             req_stall,
   output logic             push,
   output tick_type         push_data
);

   logic op_known;

   // opcode seven is no command
   assign op_known  = req_data.opcode inside {[OP_START:OP_GETACK]};
   assign req_stall = q_status.full;
   assign push      = req_valid && !q_status.full;

   always_comb begin
      push_data.start      = req_data.cmd_valid && op_known;
      push_data.op         = opcode_type'(req_data.opcode);
      push_data.tx_byte    = req_data.tx_byte;
      push_data.sda_sample = req_data.sda_sample;
   end

endmodule

### rtl/core/i2cbm_queue.sv
// small fifo of classified ticks between front and back
// depends on i2cbm_pkg

module i2cbm_queue
   import i2cbm_pkg::*;
#(
   parameter int DEPTH = 2
)(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  tick_type         push_data,
   input  logic             pop,
   output tick_type         pop_data,
   output queue_status_type q_status
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST  = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULLC = CW'(DEPTH);

   tick_type      mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign q_status.full  = (count_ff == FULLC);
   assign q_status.empty = (count_ff == '0);
   assign pop_data       = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/core/i2cbm_back.sv
// back end: bit sequencer, timeout register and result register
// depends on i2cbm_pkg

module i2cbm_back
   import i2cbm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  tick_type         tick,
   input  queue_status_type q_status,
   output logic             pop,
   input  logic             csr_valid,
   input  logic [7:0]       csr_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data
);

   localparam logic [2:0] P0 = 3'd0;
   localparam logic [2:0] P1 = 3'd1;
   localparam logic [2:0] P2 = 3'd2;
   localparam logic [2:0] P3 = 3'd3;
   localparam logic [2:0] P4 = 3'd4;
   localparam logic [2:0] P5 = 3'd5;
   localparam logic [2:0] P6 = 3'd6;

   logic [7:0] timeout_ff;
   opcode_type cmd_ff, cmd_in;
   logic [2:0] phase_ff, phase_in;
   logic [3:0] bit_ff, bit_in;
   logic [7:0] shift_ff, shift_in;
   logic [7:0] wait_ff, wait_in;
   logic       scl_ff, scl_in;
   logic       sda_ff, sda_in;
   logic       busy_ff, busy_in;
   logic       ack_ff, ack_in;
   logic [7:0] rx_ff, rx_in;
   logic       fin, busy_out;
   logic       rsp_valid_ff;
   rsp_type    rsp_data_ff;

   assign pop       = !q_status.empty && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      cmd_in   = cmd_ff;
      phase_in = phase_ff;
      bit_in   = bit_ff;
      shift_in = shift_ff;
      wait_in  = wait_ff;
      scl_in   = scl_ff;
      sda_in   = sda_ff;
      busy_in  = busy_ff;
      ack_in   = ack_ff;
      rx_in    = rx_ff;
      fin      = 1'b0;
      busy_out = 1'b0;

      // a command starts only while idle, and its first tick runs at once
      if (!busy_ff && tick.start) begin
         busy_in  = 1'b1;
         cmd_in   = tick.op;
         phase_in = P0;
         bit_in   = '0;
         wait_in  = '0;
         shift_in = (tick.op == OP_WRITE) ? tick.tx_byte : 8'd0;
      end

      if (busy_in) begin
         busy_out = 1'b1;
         case (cmd_in)
            OP_START: begin
               if (phase_in == P0) begin
                  scl_in = 1'b1; sda_in = 1'b1; phase_in = P1;
               end else if (phase_in == P1) begin
                  sda_in = 1'b0; phase_in = P2;
               end else begin
                  scl_in = 1'b0; fin = 1'b1;
               end
            end
            OP_STOP: begin
               if (phase_in == P0) begin
                  sda_in = 1'b0; phase_in = P1;
               end else if (phase_in == P1) begin
                  scl_in = 1'b1; phase_in = P2;
               end else begin
                  sda_in = 1'b1; fin = 1'b1;
               end
            end
            OP_WRITE: begin
               if (phase_in == P0) begin
                  sda_in   = shift_in[7];
                  scl_in   = 1'b1;
                  phase_in = P1;
               end else begin
                  scl_in   = 1'b0;
                  shift_in = {shift_in[6:0], 1'b0};
                  bit_in   = bit_in + 4'd1;
                  if (bit_in >= BITS_PER_BYTE) fin = 1'b1;
                  else phase_in = P0;
               end
            end
            OP_READ: begin
               if (phase_in == P0) begin
                  sda_in   = 1'b1;
                  scl_in   = 1'b1;
                  shift_in = {shift_in[6:0], tick.sda_sample};
                  phase_in = P1;
               end else begin
                  scl_in = 1'b0;
                  bit_in = bit_in + 4'd1;
                  if (bit_in >= BITS_PER_BYTE) begin
                     rx_in = shift_in;
                     fin   = 1'b1;
                  end else begin
                     phase_in = P0;
                  end
               end
            end
            OP_ACK: begin
               if (phase_in == P0) begin
                  sda_in = 1'b0; phase_in = P1;
               end else if (phase_in == P1) begin
                  scl_in = 1'b1; phase_in = P2;
               end else if (phase_in == P2) begin
                  scl_in = 1'b0; phase_in = P3;
               end else begin
                  sda_in = 1'b1; fin = 1'b1;
               end
            end
            OP_NACK: begin
               if (phase_in == P0) begin
                  sda_in = 1'b1; phase_in = P1;
               end else if (phase_in == P1) begin
                  scl_in = 1'b1; phase_in = P2;
               end else begin
                  scl_in = 1'b0; fin = 1'b1;
               end
            end
            OP_GETACK: begin
               case (phase_in)
                  P0: begin sda_in = 1'b1; phase_in = P1; end
                  P1: begin scl_in = 1'b1; phase_in = P2; end
                  P2: begin
                     // wait for the slave to pull sda low
                     if (!tick.sda_sample) phase_in = P3;
                     else if (wait_in >= timeout_ff) phase_in = P4;
                     else wait_in = wait_in + 8'd1;
                  end
                  P3: begin scl_in = 1'b0; ack_in = 1'b1; fin = 1'b1; end
                  // timeout: stop sequence
                  P4: begin sda_in = 1'b0; phase_in = P5; end
                  P5: begin scl_in = 1'b1; phase_in = P6; end
                  default: begin sda_in = 1'b1; ack_in = 1'b0; fin = 1'b1; end
               endcase
            end
            default: begin
               fin = 1'b0;
            end
         endcase
         if (fin) begin
            busy_in  = 1'b0;
            phase_in = P0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff   <= TIMEOUT_RESET;
         cmd_ff       <= OP_START;
         phase_ff     <= P0;
         bit_ff       <= '0;
         shift_ff     <= '0;
         wait_ff      <= '0;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         busy_ff      <= 1'b0;
         ack_ff       <= 1'b0;
         rx_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            timeout_ff <= csr_data;
         end
         if (pop) begin
            cmd_ff   <= cmd_in;
            phase_ff <= phase_in;
            bit_ff   <= bit_in;
            shift_ff <= shift_in;
            wait_ff  <= wait_in;
            scl_ff   <= scl_in;
            sda_ff   <= sda_in;
            busy_ff  <= busy_in;
            ack_ff   <= ack_in;
            rx_ff    <= rx_in;
         end
         if (pop) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_data_ff.scl_level <= scl_in;
         rsp_data_ff.sda_level <= sda_in;
         rsp_data_ff.busy_res  <= busy_out;
         rsp_data_ff.done_res  <= fin;
         rsp_data_ff.rx_byte   <= rx_in;
         rsp_data_ff.ack_ok    <= ack_in;
      end
   end

endmodule

### rtl/core/i2c_bit_level_master_core.sv
// top level of the tick-driven i2c bit-level master
// depends on i2cbm_pkg, i2cbm_front, i2cbm_queue, i2cbm_back

// usage:
//   every request item is one delay period (tick) of the bus; it may carry a
//   command (start, stop, write byte, read byte, ack, nack, get ack) and always
//   carries the sampled sda level. every request item gives exactly one
//   response item with the scl/sda drive levels for that period, busy, a done
//   pulse, the last received byte and the last ack status.
//   commands that arrive while a sequence runs are dropped.
// channels:
//   req_valid/req_stall/req_data in, rsp_valid/rsp_stall/rsp_data out;
//   an item moves when valid is high and stall is low.
//   csr_valid/csr_ready/csr_data writes ack_timeout; csr_ready is always high.
// throughput:
//   one item per cycle sustained while rsp_stall is low; a response passes through
//   the queue and then the result register. the sequencer state update is the
//   loop that sets this rate.
// reset:
//   synchronous; queue empty, drives released high, ack_timeout back to 200.
// stall:
//   a stalled response holds; the queue keeps taking ticks until full, then
//   req_stall rises.

module i2c_bit_level_master_core
   import i2cbm_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
)(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_data
);

   queue_status_type q_status;
   logic             push;
   logic             pop;
   tick_type         push_data;
   tick_type         pop_data;

   // the timeout register is always writable
   assign csr_ready = 1'b1;

   // front: classify and enqueue
   i2cbm_front u_front (
      .req_valid (req_valid),
      .req_data  (req_data),
      .q_status  (q_status),
      .req_stall (req_stall),
      .push      (push),
      .push_data (push_data)
   );

   // decoupling queue
   i2cbm_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .q_status  (q_status)
   );

   // back: sequencer and result register
   i2cbm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .tick      (pop_data),
      .q_status  (q_status),
      .pop       (pop),
      .csr_valid (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // a done pulse only ends a running sequence
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.done_res |-> rsp_data.busy_res)
      else $error("done without busy");

   // a stalled front means the queue holds ticks
   a_stall_nonempty: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> !q_status.empty)
      else $error("request stalled with empty queue");

   // a new response only comes from a tick taken from the queue
   a_rsp_from_queue: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!q_status.empty))
      else $error("response without queued tick");

endmodule

### dv/i2c_bit_level_master_core_tb.sv
// self-checking bench for i2c_bit_level_master_core: drives ticks, predicts every tick result
// depends on i2cbm_pkg and the i2c_bit_level_master_core rtl

`timescale 1ns / 1ps

module i2c_bit_level_master_core_tb;
   import i2cbm_pkg::*;

   localparam logic [2:0] OPCODE_RESERVED = 3'd7;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int HOLD_CYCLES = 64;
   localparam int DRAIN_CYCLES = 4;
   localparam int RANDOM_TICKS = 240;
   localparam int REPORT_MAX = 10;

   logic       clock;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   req_type    req_data = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   rsp_type    rsp_data;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [7:0] csr_data = 8'd0;

   i2c_bit_level_master_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // bus sequencer mirror, advanced once per accepted tick
   opcode_type bus_op;
   logic [2:0] bus_step;
   logic [3:0] bit_cnt;
   logic [7:0] shift_q;
   logic [7:0] ack_wait_cnt;
   logic       scl_q;
   logic       sda_q;
   logic       seq_busy;
   logic       ack_q;
   logic [7:0] rx_q;
   logic [7:0] timeout_q;

   // results owed by the block, oldest first
   rsp_type levels_due[$];

   int  fail_count = 0;
   int  active_ticks = 0;
   int  burst_left = 0;
   bit  gaps_on = 1'b0;
   int  stall_mode = 0;
   bit  hold_start = 1'b0;
   int  hold_left = 0;
   int  stall_tick = 0;
   int  quiet_cycles = 0;

   function automatic void bus_reset();
      bus_op = OP_START;
      bus_step = 3'd0;
      bit_cnt = 4'd0;
      shift_q = 8'd0;
      ack_wait_cnt = 8'd0;
      scl_q = 1'b1;
      sda_q = 1'b1;
      seq_busy = 1'b0;
      ack_q = 1'b0;
      rx_q = 8'd0;
      timeout_q = TIMEOUT_RESET;
   endfunction

   // one tick of the sequencer: launch a command when idle, then run a step
   function automatic rsp_type bus_tick(input req_type t);
      rsp_type r;
      logic    fin;
      fin = 1'b0;
      r = '0;
      if (!seq_busy && t.cmd_valid && t.opcode <= OP_GETACK) begin
         seq_busy = 1'b1;
         bus_op = opcode_type'(t.opcode);
         bus_step = 3'd0;
         bit_cnt = 4'd0;
         ack_wait_cnt = 8'd0;
         shift_q = (bus_op == OP_WRITE) ? t.tx_byte : 8'd0;
      end
      if (seq_busy) begin
         r.busy_res = 1'b1;
         case (bus_op)
            OP_START: begin
               if (bus_step == 3'd0) begin
                  scl_q = 1'b1;
                  sda_q = 1'b1;
                  bus_step = 3'd1;
               end else if (bus_step == 3'd1) begin
                  sda_q = 1'b0;
                  bus_step = 3'd2;
               end else begin
                  scl_q = 1'b0;
                  fin = 1'b1;
               end
            end
            OP_STOP: begin
               if (bus_step == 3'd0) begin
                  sda_q = 1'b0;
                  bus_step = 3'd1;
               end else if (bus_step == 3'd1) begin
                  scl_q = 1'b1;
                  bus_step = 3'd2;
               end else begin
                  sda_q = 1'b1;
                  fin = 1'b1;
               end
            end
            OP_WRITE: begin
               if (bus_step == 3'd0) begin
                  sda_q = shift_q[7];
                  scl_q = 1'b1;
                  bus_step = 3'd1;
               end else begin
                  scl_q = 1'b0;
                  shift_q = shift_q << 1;
                  bit_cnt = bit_cnt + 4'd1;
                  if (bit_cnt >= BITS_PER_BYTE) fin = 1'b1;
                  else bus_step = 3'd0;
               end
            end
            OP_READ: begin
               if (bus_step == 3'd0) begin
                  sda_q = 1'b1;
                  scl_q = 1'b1;
                  shift_q = {shift_q[6:0], t.sda_sample};
                  bus_step = 3'd1;
               end else begin
                  scl_q = 1'b0;
                  bit_cnt = bit_cnt + 4'd1;
                  if (bit_cnt >= BITS_PER_BYTE) begin
                     rx_q = shift_q;
                     fin = 1'b1;
                  end else begin
                     bus_step = 3'd0;
                  end
               end
            end
            OP_ACK: begin
               if (bus_step == 3'd0) begin
                  sda_q = 1'b0;
                  bus_step = 3'd1;
               end else if (bus_step == 3'd1) begin
                  scl_q = 1'b1;
                  bus_step = 3'd2;
               end else if (bus_step == 3'd2) begin
                  scl_q = 1'b0;
                  bus_step = 3'd3;
               end else begin
                  sda_q = 1'b1;
                  fin = 1'b1;
               end
            end
            OP_NACK: begin
               if (bus_step == 3'd0) begin
                  sda_q = 1'b1;
                  bus_step = 3'd1;
               end else if (bus_step == 3'd1) begin
                  scl_q = 1'b1;
                  bus_step = 3'd2;
               end else begin
                  scl_q = 1'b0;
                  fin = 1'b1;
               end
            end
            default: begin
               // get ack: release, clock high, wait for a low sample or time out
               case (bus_step)
                  3'd0: begin
                     sda_q = 1'b1;
                     bus_step = 3'd1;
                  end
                  3'd1: begin
                     scl_q = 1'b1;
                     bus_step = 3'd2;
                  end
                  3'd2: begin
                     if (!t.sda_sample) bus_step = 3'd3;
                     else if (ack_wait_cnt >= timeout_q) bus_step = 3'd4;
                     else ack_wait_cnt = ack_wait_cnt + 8'd1;
                  end
                  3'd3: begin
                     scl_q = 1'b0;
                     ack_q = 1'b1;
                     fin = 1'b1;
                  end
                  3'd4: begin
                     sda_q = 1'b0;
                     bus_step = 3'd5;
                  end
                  3'd5: begin
                     scl_q = 1'b1;
                     bus_step = 3'd6;
                  end
                  default: begin
                     sda_q = 1'b1;
                     ack_q = 1'b0;
                     fin = 1'b1;
                  end
               endcase
            end
         endcase
         if (fin) begin
            r.done_res = 1'b1;
            seq_busy = 1'b0;
            bus_step = 3'd0;
         end
      end
      r.scl_level = scl_q;
      r.sda_level = sda_q;
      r.rx_byte = rx_q;
      r.ack_ok = ack_q;
      return r;
   endfunction

   // sda a slave would return: read bits from rx_want, ack after ack_after high samples
   function automatic logic slave_sda(input opcode_type op, input logic [2:0] step,
                                      input logic [3:0] bits, input logic [7:0] waited,
                                      input logic [7:0] rx_want, input int ack_after);
      if (op == OP_READ && step == 3'd0) return rx_want[7 - bits];
      if (op == OP_GETACK && step == 3'd2) return (waited >= ack_after) ? 1'b0 : 1'b1;
      return 1'($urandom_range(0, 1));
   endfunction

   function automatic int pick_ack_after();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(0, 3);
      if (r < ((timeout_q <= 8'd20) ? 90 : 74)) return int'(timeout_q) + 1;
      return $urandom_range(0, (timeout_q < 8'd20) ? int'(timeout_q) : 20);
   endfunction

   task automatic note_failure(input string what, input rsp_type want, input rsp_type got);
      fail_count++;
      if (fail_count <= REPORT_MAX)
         $display("%0t %s: want scl=%0b sda=%0b busy=%0b done=%0b rx=%02h ack=%0b,",
                  $realtime, what, want.scl_level, want.sda_level, want.busy_res,
                  want.done_res, want.rx_byte, want.ack_ok,
                  " got scl=%0b sda=%0b busy=%0b done=%0b rx=%02h ack=%0b",
                  got.scl_level, got.sda_level, got.busy_res, got.done_res,
                  got.rx_byte, got.ack_ok);
   endtask

   // sends one tick, idling between bursts; predicts its result once accepted
   task automatic send_tick(input req_type t);
      rsp_type r;
      if (gaps_on && burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 16);
      end
      if (burst_left > 0) burst_left--;
      req_valid <= 1'b1;
      req_data <= t;
      do @(posedge clock); while (req_stall);
      r = bus_tick(t);
      levels_due.push_back(r);
      if (r.busy_res) active_ticks++;
   endtask

   // issues a command tick and then feeds ticks until its sequence completes
   task automatic run_command(input logic [2:0] op, input logic [7:0] tx,
                              input logic [7:0] rx_want, input int ack_after, input bit noisy);
      req_type t;
      t.cmd_valid = 1'b1;
      t.opcode = op;
      t.tx_byte = tx;
      if (!seq_busy && op <= OP_GETACK)
         t.sda_sample = slave_sda(opcode_type'(op), 3'd0, 4'd0, 8'd0, rx_want, ack_after);
      else
         t.sda_sample = 1'($urandom_range(0, 1));
      send_tick(t);
      while (seq_busy) begin
         // noisy sequences throw in commands that a busy block must drop
         t.cmd_valid = noisy && ($urandom_range(0, 5) == 0);
         t.opcode = 3'($urandom_range(0, 7));
         t.tx_byte = 8'($urandom);
         t.sda_sample = slave_sda(bus_op, bus_step, bit_cnt, ack_wait_cnt, rx_want, ack_after);
         send_tick(t);
      end
   endtask

   // ticks that start nothing: no command or the unused opcode
   task automatic idle_ticks(input int n);
      req_type t;
      repeat (n) begin
         t.cmd_valid = 1'($urandom_range(0, 1));
         t.opcode = t.cmd_valid ? OPCODE_RESERVED : 3'($urandom_range(0, 7));
         t.tx_byte = 8'($urandom);
         t.sda_sample = 1'($urandom_range(0, 1));
         send_tick(t);
      end
   endtask

   // drop valid, wait for every owed result, then let the pipeline empty
   task automatic settle();
      req_valid <= 1'b0;
      while (levels_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_ack_timeout(input logic [7:0] value);
      while (seq_busy) idle_ticks(1);
      settle();
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      timeout_q = value;
   endtask

   // receiver: long hold when asked, otherwise stalls by mode
   always @(posedge clock) begin
      stall_tick++;
      if (hold_start) begin
         hold_start = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 2) == 0);
            default: rsp_stall <= (stall_tick % 5 == 0) || (stall_tick % 11 < 3);
         endcase
      end
   end

   // result checker: every result must match the oldest owed one
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (levels_due.size() == 0) begin
            note_failure("unexpected result", rsp_data, rsp_data);
         end else begin
            want = levels_due.pop_front();
            if (rsp_data.scl_level !== want.scl_level || rsp_data.sda_level !== want.sda_level ||
                rsp_data.busy_res !== want.busy_res || rsp_data.done_res !== want.done_res ||
                rsp_data.rx_byte !== want.rx_byte || rsp_data.ack_ok !== want.ack_ok)
               note_failure("result mismatch", want, rsp_data);
         end
      end
   end

   // watchdog: ends the run when no channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   task automatic test_each_command();
      gaps_on = 1'b1;
      stall_mode = 1;
      run_command(OP_STOP, 8'h00, 8'h00, 0, 1'b0);         // stop from idle
      run_command(OP_START, 8'h00, 8'h00, 0, 1'b0);
      run_command(OP_WRITE, 8'hFF, 8'h00, 0, 1'b0);
      run_command(OP_GETACK, 8'h00, 8'h00, 0, 1'b0);        // ack on first sample
      run_command(OP_WRITE, 8'h00, 8'h00, 0, 1'b0);
      run_command(OP_GETACK, 8'hFF, 8'h00, 5, 1'b0);
      run_command(OP_WRITE, 8'hA5, 8'h00, 0, 1'b1);         // commands while busy
      run_command(OP_READ, 8'h00, 8'hFF, 0, 1'b0);
      run_command(OP_ACK, 8'h00, 8'h00, 0, 1'b0);
      run_command(OP_READ, 8'hFF, 8'h00, 0, 1'b1);
      run_command(OP_NACK, 8'h00, 8'h00, 0, 1'b0);
      run_command(OPCODE_RESERVED, 8'hFF, 8'h00, 0, 1'b0);  // unused opcode stays idle
      idle_ticks(2);
      run_command(OP_READ, 8'h00, 8'h5A, 0, 1'b0);
      run_command(OP_GETACK, 8'h00, 8'h00, int'(TIMEOUT_RESET) + 1, 1'b0); // reset timeout
      run_command(OP_STOP, 8'h00, 8'h00, 0, 1'b0);
   endtask

   task automatic test_timeout_extremes();
      logic [7:0] tmo;
      gaps_on = 1'b0;
      stall_mode = 2;
      for (int i = 0; i < 3; i++) begin
         tmo = (i == 0) ? 8'd0 : (i == 1) ? 8'd1 : 8'd255;
         set_ack_timeout(tmo);
         // ack on the last allowed sample, then one sample too late
         // the long wait at the top value runs only as a timeout
         if (i < 2) run_command(OP_GETACK, 8'h00, 8'h00, int'(tmo), 1'b0);
         run_command(OP_GETACK, 8'h00, 8'h00, int'(tmo) + 1, 1'b1);
      end
   endtask

   task automatic test_backpressure();
      gaps_on = 1'b0;
      stall_mode = 0;
      hold_start = 1'b1;
      // keep offering ticks so the queue fills and req_stall rises
      run_command(OP_START, 8'h00, 8'h00, 0, 1'b0);
      run_command(OP_WRITE, 8'h3C, 8'h00, 0, 1'b0);
      run_command(OP_GETACK, 8'h00, 8'h00, 1, 1'b0);
      run_command(OP_READ, 8'h00, 8'hC3, 0, 1'b0);
      run_command(OP_NACK, 8'h00, 8'h00, 0, 1'b0);
      run_command(OP_STOP, 8'h00, 8'h00, 0, 1'b0);
   endtask

   // one bus transaction: start, address, ack, up to three data bytes, stop; now and then junk commands instead
   task automatic random_session();
      logic [7:0] addr;
      int         nbytes;
      bit         noisy;
      if ($urandom_range(0, 9) == 0) begin
         // junk: random commands in any order
         repeat ($urandom_range(1, 6))
            run_command(3'($urandom_range(0, 7)), 8'($urandom), 8'($urandom),
                        pick_ack_after(), 1'b1);
         return;
      end
      addr = 8'($urandom);
      noisy = ($urandom_range(0, 3) == 0);
      run_command(OP_START, 8'($urandom), 8'($urandom), 0, noisy);
      idle_ticks($urandom_range(0, 2));
      run_command(OP_WRITE, addr, 8'($urandom), 0, noisy);
      run_command(OP_GETACK, 8'($urandom), 8'($urandom), pick_ack_after(), noisy);
      nbytes = $urandom_range(0, 3);
      for (int k = 0; k < nbytes; k++) begin
         if (addr[0]) begin
            run_command(OP_READ, 8'($urandom), 8'($urandom), 0, noisy);
            run_command((k == nbytes - 1) ? OP_NACK : OP_ACK, 8'($urandom), 8'($urandom),
                        0, noisy);
         end else begin
            run_command(OP_WRITE, 8'($urandom), 8'($urandom), 0, noisy);
            run_command(OP_GETACK, 8'($urandom), 8'($urandom), pick_ack_after(), noisy);
         end
         if ($urandom_range(0, 4) == 0) idle_ticks($urandom_range(1, 3));
      end
      // now and then the stop is left out
      if ($urandom_range(0, 9) != 0)
         run_command(OP_STOP, 8'($urandom), 8'($urandom), 0, noisy);
   endtask

   task automatic test_random_traffic();
      int         base;
      logic [7:0] tmo;
      base = active_ticks;
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: tmo = 8'($urandom_range(0, 15));
            1: tmo = 8'd0;
            2: tmo = 8'd255;
            3: tmo = 8'($urandom);
            4: tmo = 8'($urandom_range(1, 4));
            default: tmo = TIMEOUT_RESET;
         endcase
         set_ack_timeout(tmo);
         gaps_on = (ph % 2 == 0);
         stall_mode = ph % 3;
         while (active_ticks < base + (ph + 1) * RANDOM_TICKS / 6) random_session();
      end
   endtask

   initial begin
      bus_reset();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_each_command();
      test_timeout_extremes();
      test_backpressure();
      test_random_traffic();
      settle();
      if (fail_count == 0 && levels_due.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
